/* src/lmul_pkg.sv */
package lmul_pkg;

  localparam int ExpBits  = 4;
  localparam int ManBits  = 3;
  localparam int CodeBits = ExpBits + ManBits + 1;
  localparam int CodeBias = (1 << (ExpBits - 1)) - 1;
  localparam int DropBits = 23 - ManBits;
  localparam int LmBits   = (ManBits <= 3) ? ManBits : ((ManBits == 4) ? 3 : 4);
  localparam int SumBits  = ManBits + 2;

  localparam logic [ExpBits-1:0] ExpMax = {ExpBits{1'b1}};
  localparam logic [ManBits-1:0] ManMax = {ManBits{1'b1}};

  typedef struct packed {
    logic               sign;
    logic [ExpBits-1:0] exp;
    logic [ManBits-1:0] man;
  } code_t;

endpackage

/* src/lmul_round.sv */
// Cuts an FP32 operand to the minifloat code with stochastic rounding,
// split over two register stages: classify and compare, then increment.
module lmul_round (
  input  logic                            clk,
  input  logic [31:0]                     bits,
  input  logic [19:0]                     rnd,
  output lmul_pkg::code_t                 code
);

  logic                                   sign;
  logic [lmul_pkg::ExpBits-1:0]           exp;
  logic [lmul_pkg::ManBits-1:0]           man;
  logic                                   bump;
  logic [9:0]                             fe;
  logic [lmul_pkg::DropBits-1:0]          rem;
  logic [lmul_pkg::DropBits+19:0]         lhs;
  logic [lmul_pkg::DropBits+19:0]         rhs;
  logic [lmul_pkg::ExpBits-1:0]           exp_next;
  logic [lmul_pkg::ManBits-1:0]           man_next;
  logic                                   bump_next;

  always_comb begin
    fe  = {2'b00, bits[30:23]} - 10'd127 + 10'(lmul_pkg::CodeBias);
    rem = bits[lmul_pkg::DropBits-1:0];
    lhs = {rnd, {lmul_pkg::DropBits{1'b0}}};
    rhs = {rem, 20'd0};
    bump_next = 1'b0;
    if (fe[9] || fe == 10'd0) begin
      exp_next = '0;
      man_next = '0;
    end else if (fe > 10'(lmul_pkg::ExpMax)) begin
      exp_next = lmul_pkg::ExpMax;
      man_next = lmul_pkg::ManMax;
    end else begin
      exp_next = fe[lmul_pkg::ExpBits-1:0];
      man_next = bits[22:lmul_pkg::DropBits];
      bump_next = (lhs < rhs) && (man_next != lmul_pkg::ManMax);
    end
  end

  always_ff @(posedge clk) begin
    sign <= bits[31];
    exp  <= exp_next;
    man  <= man_next;
    bump <= bump_next;
  end

  always_ff @(posedge clk) begin
    code.sign <= sign;
    code.exp  <= exp;
    code.man  <= man + lmul_pkg::ManBits'(bump);
  end

endmodule

/* src/lmul_fp8_approx_multiply_core.sv */
// Channel   Ports                                  Handshake
// request   x_bits, y_bits, rand_x, rand_y         start high, busy low
// result    product_bits, x_code, y_code           done strobe, one cycle
//
// Four register stages: two for rounding, one for the L-Mul sum, one for
// normalizing into FP32. An item enters every cycle; busy stays low, and
// each result leaves the output register together with done. Reset clears the
// valid bits only. The receiver cannot stall, so nothing ever waits.
module lmul_fp8_approx_multiply_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] x_bits,
  input  logic [31:0] y_bits,
  input  logic [19:0] rand_x,
  input  logic [19:0] rand_y,
  output logic        done,
  output logic [31:0] product_bits,
  output logic [7:0]  x_code,
  output logic [7:0]  y_code
);

  localparam int SB = lmul_pkg::SumBits;
  localparam int MB = lmul_pkg::ManBits;

  logic [3:0]             valid;
  lmul_pkg::code_t        cx;
  lmul_pkg::code_t        cy;
  lmul_pkg::code_t        cx3;
  lmul_pkg::code_t        cy3;
  logic                   zero3;
  logic                   sign3;
  logic [SB-1:0]          sum;
  logic [lmul_pkg::ExpBits:0] esum;
  logic                   wide;
  logic [SB-1:0]          frac_n;
  logic [9:0]             e;
  logic [22:0]            frac;

  assign busy = 1'b0;

  lmul_round u_round_x (.clk(clk), .bits(x_bits), .rnd(rand_x), .code(cx));
  lmul_round u_round_y (.clk(clk), .bits(y_bits), .rnd(rand_y), .code(cy));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[2:0], start};
    end
  end

  // Stage three: mantissa sum with the 2^-lm offset, exponent sum.
  always_ff @(posedge clk) begin
    cx3   <= cx;
    cy3   <= cy;
    sign3 <= cx.sign ^ cy.sign;
    zero3 <= (cx.exp == '0) || (cy.exp == '0);
    sum   <= SB'(1 << MB) + SB'(cx.man) + SB'(cy.man)
             + SB'(1 << (MB - lmul_pkg::LmBits));
    esum  <= {1'b0, cx.exp} + {1'b0, cy.exp};
  end

  always_comb begin
    wide   = sum[SB-1];
    frac_n = wide ? (sum - SB'(1 << (MB + 1))) : (sum - SB'(1 << MB));
    frac   = wide ? (23'(frac_n) << (22 - MB)) : (23'(frac_n) << (23 - MB));
    e      = 10'(esum) - 10'(2 * lmul_pkg::CodeBias) + 10'(wide) + 10'd127;
  end

  always_ff @(posedge clk) begin
    x_code <= 8'(cx3);
    y_code <= 8'(cy3);
    product_bits <= zero3 ? {sign3, 31'd0} : {sign3, e[7:0], frac};
  end

  assign done = valid[3];

endmodule
